/* rtl/tfdf_pkg.sv */
package tfdf_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam logic [31:0] DUP_WINDOW_RST = 32'd50;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int NUM_W    = 64;

  // tdata widths, rounded up to whole bytes
  localparam int IN_FIELDS_W  = 355;
  localparam int IN_TDATA_W   = 360;
  localparam int OUT_FIELDS_W = 419;
  localparam int OUT_TDATA_W  = 424;

  // operation codes on in_tuser
  localparam logic [MODE_W-1:0] MODE_ENQ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TAKE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // result codes on out_tuser
  localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEQ     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd6;

  // fields used by the duplicate test
  typedef struct packed {
    logic [63:0]        resolver;
    logic               trust;
    logic signed [31:0] held;
    logic signed [31:0] asked;
    logic [63:0]        object;
    logic [63:0]        manager;
    logic [1:0]         kind;
    logic [31:0]        tick;
  } key_t;

  // one stored record
  typedef struct packed {
    logic [63:0] payload;
    key_t        key;
    logic [63:0] seq;
  } rec_t;

endpackage

/* rtl/tfdf_store.sv */
module tfdf_store #(
  parameter int DEPTH = tfdf_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  tfdf_pkg::rec_t      wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output tfdf_pkg::rec_t      rd_data
);

  tfdf_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tfdf_dup_filter.sv */
module tfdf_dup_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  logic                load,
  input  tfdf_pkg::key_t      key,
  input  logic [31:0]         window,
  output logic                is_dup
);

  logic           have_last_r;
  tfdf_pkg::key_t last_r;
  logic [31:0]    tick_gap;

  // wrapping tick distance from the last stored record
  assign tick_gap = key.tick - last_r.tick;

  assign is_dup = have_last_r && (tick_gap <= window) &&
                  (key.kind == last_r.kind) && (key.manager == last_r.manager) &&
                  (key.object == last_r.object) && (key.asked == last_r.asked) &&
                  (key.held == last_r.held) && (key.trust == last_r.trust) &&
                  (key.resolver == last_r.resolver);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      have_last_r <= 1'b0;
      last_r      <= '0;
    end else if (load) begin
      have_last_r <= 1'b1;
      last_r      <= key;
    end
  end

endmodule

/* rtl/trace_fifo_with_duplicate_filter.sv */
// trace record queue with a filter that drops repeats of the last stored record
//
// in_* channel: one beat is one operation, selected by in_tuser (enqueue,
// dequeue, take drop count, clear all); tdata carries the record fields.
// out_* channel: exactly one result beat per input beat, in order; out_tuser
// gives the status, tdata the sequence number or drop count and, for a
// dequeue, the popped record (all other fields zero).
// cfg_*: a single write-only register, the duplicate tick window (reset 50).
//
// a beat passes the pending stage, then the output register: the queue state
// is updated at acceptance while the record memory is read, and the result is
// formed from the registered memory data as it enters the output register
// throughput is one beat per cycle while out_tready stays high; the record
// memory has one write and one read port and each beat uses at most one
// a held result stalls the block: one finished beat waits in the output
// register and one more in the pending stage, then in_tready drops
// synchronous reset (and a clear operation) empty the queue, zero both
// counters and forget the last record; memory contents are left as they are
// and never read before being written
module trace_fifo_with_duplicate_filter #(
  parameter int QUEUE_DEPTH = tfdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config register
  input  logic                                 cfg_wr_en,
  input  logic [31:0]                          cfg_wr_data,   // dup_window
  // operation beats
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // event_time, event_kind, manager_ref, object_ref, asked_index,
  // held_index, trust_flag, resolver_key, extra_payload, zero pad
  input  logic [tfdf_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [tfdf_pkg::MODE_W-1:0]          in_tuser,      // mode
  // result beats
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // number_out, out_time, out_kind, out_manager, out_object, out_asked,
  // out_held, out_trust, out_resolver, out_payload, zero pad
  output logic [tfdf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [tfdf_pkg::STATUS_W-1:0]        out_tuser      // status
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // queue control state
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic [63:0]    seq_cnt_r, seq_cnt_nxt;
  logic [63:0]    drop_cnt_r, drop_cnt_nxt;
  logic [31:0]    dup_window_r;

  // pending stage: result decided, waiting on the memory read
  logic                           p_valid_r;
  logic                           p_deq_r, p_deq_nxt;
  logic [tfdf_pkg::STATUS_W-1:0]  p_status_r, p_status_nxt;
  logic [63:0]                    p_num_r, p_num_nxt;

  // output register
  logic                              out_valid_r;
  logic [tfdf_pkg::STATUS_W-1:0]     out_status_r;
  logic [tfdf_pkg::OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  logic                 in_acc, p_adv;
  logic [tfdf_pkg::MODE_W-1:0] mode;
  tfdf_pkg::key_t       in_key;
  logic [63:0]          in_payload;
  tfdf_pkg::rec_t       wr_rec, rd_rec;
  logic                 is_dup, full, empty;
  logic                 wr_en, rd_en, filt_load, filt_clear;

  // unpack the input beat
  assign mode       = in_tuser;
  assign in_key     = tfdf_pkg::key_t'(in_tdata[290:0]);
  assign in_payload = in_tdata[354:291];

  assign full  = (fill_cnt_r == CW'(QUEUE_DEPTH));
  assign empty = (fill_cnt_r == '0);

  // pending result moves on when the output register is free or draining
  assign p_adv     = p_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p_valid_r || p_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign wr_rec = '{payload: in_payload, key: in_key, seq: seq_cnt_r + 64'd1};

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // operation decode, all queue state changes happen at acceptance
  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    fill_cnt_nxt = fill_cnt_r;
    seq_cnt_nxt  = seq_cnt_r;
    drop_cnt_nxt = drop_cnt_r;
    p_deq_nxt    = 1'b0;
    p_status_nxt = tfdf_pkg::ST_CLEARED;
    p_num_nxt    = '0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    filt_load    = 1'b0;
    filt_clear   = 1'b0;
    if (in_acc) begin
      unique case (mode)
        tfdf_pkg::MODE_ENQ: begin
          if (is_dup) begin
            p_status_nxt = tfdf_pkg::ST_DUP;
          end else if (full) begin
            p_status_nxt = tfdf_pkg::ST_FULL;
            drop_cnt_nxt = drop_cnt_r + 64'd1;
          end else begin
            p_status_nxt = tfdf_pkg::ST_QUEUED;
            seq_cnt_nxt  = wr_rec.seq;
            p_num_nxt    = wr_rec.seq;
            wr_en        = 1'b1;
            filt_load    = 1'b1;
            wr_ptr_nxt   = ptr_inc(wr_ptr_r);
            fill_cnt_nxt = fill_cnt_r + 1'b1;
          end
        end
        tfdf_pkg::MODE_DEQ: begin
          if (empty) begin
            p_status_nxt = tfdf_pkg::ST_EMPTY;
          end else begin
            p_status_nxt = tfdf_pkg::ST_DEQ;
            p_deq_nxt    = 1'b1;
            rd_en        = 1'b1;
            rd_ptr_nxt   = ptr_inc(rd_ptr_r);
            fill_cnt_nxt = fill_cnt_r - 1'b1;
          end
        end
        tfdf_pkg::MODE_TAKE: begin
          p_status_nxt = tfdf_pkg::ST_COUNT;
          p_num_nxt    = drop_cnt_r;
          drop_cnt_nxt = '0;
        end
        tfdf_pkg::MODE_CLEAR: begin
          p_status_nxt = tfdf_pkg::ST_CLEARED;
          rd_ptr_nxt   = '0;
          wr_ptr_nxt   = '0;
          fill_cnt_nxt = '0;
          seq_cnt_nxt  = '0;
          drop_cnt_nxt = '0;
          filt_clear   = 1'b1;
        end
        default: begin
          p_status_nxt = tfdf_pkg::ST_CLEARED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      fill_cnt_r <= '0;
      seq_cnt_r  <= '0;
      drop_cnt_r <= '0;
    end else begin
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      seq_cnt_r  <= seq_cnt_nxt;
      drop_cnt_r <= drop_cnt_nxt;
    end
  end

  // window register keeps its value across a clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_window_r <= tfdf_pkg::DUP_WINDOW_RST;
    end else if (cfg_wr_en) begin
      dup_window_r <= cfg_wr_data;
    end
  end

  // pending stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_acc) begin
      p_valid_r <= 1'b1;
    end else if (p_adv) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_deq_r    <= p_deq_nxt;
      p_status_r <= p_status_nxt;
      p_num_r    <= p_num_nxt;
    end
  end

  // a dequeue takes its record from the registered memory data
  always_comb begin
    out_data_nxt = '0;
    if (p_deq_r) begin
      out_data_nxt[tfdf_pkg::OUT_FIELDS_W-1:0] = rd_rec;
    end else begin
      out_data_nxt[63:0] = p_num_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      out_status_r <= p_status_r;
      out_data_r   <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

  tfdf_dup_filter u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (filt_clear),
    .load   (filt_load),
    .key    (in_key),
    .window (dup_window_r),
    .is_dup (is_dup)
  );

  tfdf_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_rec)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= CW'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_ptr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_cnt_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("pointers differ on an empty queue");

  a_queued_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (p_status_nxt == tfdf_pkg::ST_QUEUED))
      |=> (fill_cnt_r == $past(fill_cnt_r) + 1'b1))
    else $error("queued beat did not grow the fill count");

  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && out_valid_r && !out_tready) |=> (p_valid_r && $stable(p_status_r)))
    else $error("pending result lost under stall");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("memory written and read by one beat");
`endif

endmodule
